// ===== sv/iopr_pkg.sv =====
// ----------------------------------------------------------------------------
// iopr_pkg
// request and status codes of the i/o port range table
// ----------------------------------------------------------------------------
package iopr_pkg;

   typedef logic [1:0] req_code_type;
   typedef logic [2:0] status_type;

   localparam req_code_type REQ_LOOKUP = 2'd0;
   localparam req_code_type REQ_ADD    = 2'd1;
   localparam req_code_type REQ_CLEAR  = 2'd2;

   localparam status_type STATUS_HIT     = 3'd0;
   localparam status_type STATUS_MISS    = 3'd1;
   localparam status_type STATUS_ADDED   = 3'd2;
   localparam status_type STATUS_OVERLAP = 3'd3;
   localparam status_type STATUS_FULL    = 3'd4;
   localparam status_type STATUS_CLEARED = 3'd5;

endpackage

// ===== sv/iopr_mem.sv =====
// ----------------------------------------------------------------------------
// iopr_mem
// range entry memory, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module iopr_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 41,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/io_port_range_table_unit.sv =====
// ----------------------------------------------------------------------------
// io_port_range_table_unit
// sorted table of i/o port ranges with lookup, insert and clear
//
// The table sits in one memory with registered read data and takes one
// request word at a time. A lookup scans the stored ranges in order, one
// memory read per cycle, and stops early on a hit. An add scans the entries
// for overlap and its sorted position, then shifts the entries above that
// position up by one, one read and one write per cycle, then writes the new
// entry. A clear resets the entry count. The scan and shift run through the
// single read port of the entry memory. A finished response word waits in
// the output register while the next request is taken.
// ----------------------------------------------------------------------------
module io_port_range_table_unit #(
   parameter int MAX_RANGES   = 16,
   parameter int PORT_BITS    = 16,
   parameter int HANDLER_BITS = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_type,
   input  logic [PORT_BITS-1:0]    req_port_number,
   input  logic                    req_is_read,
   input  logic [2:0]              req_access_bytes,
   input  logic [PORT_BITS-1:0]    req_new_start,
   input  logic [PORT_BITS-1:0]    req_new_end,
   input  logic [HANDLER_BITS-1:0] req_new_handler,
   input  logic                    req_new_kind,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [HANDLER_BITS-1:0] rsp_hit_handler,
   output logic                    rsp_hit_kind,
   output logic [3:0]              rsp_hit_index,
   output logic [PORT_BITS-1:0]    rsp_fwd_port,
   output logic                    rsp_fwd_is_read,
   output logic [2:0]              rsp_fwd_bytes
);

   localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W = $clog2(MAX_RANGES + 1);
   localparam int ENT_W = 2 * PORT_BITS + HANDLER_BITS + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic                    op_add_ff, op_add_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [CNT_W-1:0]        scan_ff, scan_in;
   logic                    pend_ff, pend_in;
   logic [CNT_W-1:0]        pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;

   logic [PORT_BITS-1:0]    port_ff, port_in;
   logic                    rd_ff, rd_in;
   logic [2:0]              bytes_ff, bytes_in;
   logic [PORT_BITS-1:0]    nfirst_ff, nfirst_in;
   logic [PORT_BITS-1:0]    nlast_ff, nlast_in;
   logic [HANDLER_BITS-1:0] nhand_ff, nhand_in;
   logic                    nkind_ff, nkind_in;

   iopr_pkg::status_type    res_status_ff, res_status_in;
   logic [HANDLER_BITS-1:0] res_handler_ff, res_handler_in;
   logic                    res_kind_ff, res_kind_in;
   logic [CNT_W-1:0]        res_index_ff, res_index_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   iopr_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [HANDLER_BITS-1:0] rsp_handler_ff, rsp_handler_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [3:0]              rsp_index_ff, rsp_index_in;
   logic [PORT_BITS-1:0]    rsp_port_ff, rsp_port_in;
   logic                    rsp_rd_ff, rsp_rd_in;
   logic [2:0]              rsp_bytes_ff, rsp_bytes_in;

   logic                    mem_wr_en;
   logic [IDX_W-1:0]        mem_wr_addr;
   logic [ENT_W-1:0]        mem_wr_data;
   logic                    mem_rd_en;
   logic [IDX_W-1:0]        mem_rd_addr;
   logic [ENT_W-1:0]        mem_rd_data;

   logic [PORT_BITS-1:0]    ent_first;
   logic [PORT_BITS-1:0]    ent_last;
   logic [HANDLER_BITS-1:0] ent_handler;
   logic                    ent_kind;
   logic                    req_accept;
   logic                    out_free;
   logic [CNT_W-1:0]        scan_m1;
   logic [CNT_W-1:0]        pend_p1;

   iopr_mem #(
      .DEPTH (MAX_RANGES),
      .WIDTH (ENT_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign ent_first   = mem_rd_data[ENT_W-1 -: PORT_BITS];
   assign ent_last    = mem_rd_data[HANDLER_BITS+PORT_BITS -: PORT_BITS];
   assign ent_handler = mem_rd_data[HANDLER_BITS:1];
   assign ent_kind    = mem_rd_data[0];

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign scan_m1    = scan_ff - 1'b1;
   assign pend_p1    = pend_idx_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      op_add_in      = op_add_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      pend_in        = pend_ff;
      pend_idx_in    = pend_idx_ff;
      pos_in         = pos_ff;
      port_in        = port_ff;
      rd_in          = rd_ff;
      bytes_in       = bytes_ff;
      nfirst_in      = nfirst_ff;
      nlast_in       = nlast_ff;
      nhand_in       = nhand_ff;
      nkind_in       = nkind_ff;
      res_status_in  = res_status_ff;
      res_handler_in = res_handler_ff;
      res_kind_in    = res_kind_ff;
      res_index_in   = res_index_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_handler_in = rsp_handler_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_port_in    = rsp_port_ff;
      rsp_rd_in      = rsp_rd_ff;
      rsp_bytes_in   = rsp_bytes_ff;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = pend_p1[IDX_W-1:0];
      mem_wr_data    = mem_rd_data;
      mem_rd_en      = 1'b0;
      mem_rd_addr    = scan_ff[IDX_W-1:0];

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               port_in        = req_port_number;
               rd_in          = req_is_read;
               bytes_in       = req_access_bytes;
               nfirst_in      = req_new_start;
               nlast_in       = req_new_end;
               nhand_in       = req_new_handler;
               nkind_in       = req_new_kind;
               res_handler_in = '0;
               res_kind_in    = 1'b0;
               res_index_in   = '0;
               scan_in        = '0;
               pend_in        = 1'b0;
               pos_in         = '0;
               case (req_type)
                  iopr_pkg::REQ_LOOKUP: begin
                     op_add_in = 1'b0;
                     state_in  = ST_SCAN;
                  end
                  iopr_pkg::REQ_ADD: begin
                     op_add_in = 1'b1;
                     if (req_new_start > req_new_end) begin
                        res_status_in = iopr_pkg::STATUS_OVERLAP;
                        state_in      = ST_FIN;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  iopr_pkg::REQ_CLEAR: begin
                     count_in      = '0;
                     res_status_in = iopr_pkg::STATUS_CLEARED;
                     state_in      = ST_FIN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // one read issued per cycle, its data checked in the next cycle
            if (scan_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               scan_in     = scan_ff + 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = scan_ff;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               if (!op_add_ff) begin
                  if (ent_first <= port_ff && port_ff <= ent_last) begin
                     res_status_in  = iopr_pkg::STATUS_HIT;
                     res_handler_in = ent_handler;
                     res_kind_in    = ent_kind;
                     res_index_in   = pend_idx_ff;
                     state_in       = ST_FIN;
                  end
               end else begin
                  if (ent_last >= nfirst_ff && ent_first <= nlast_ff) begin
                     res_status_in = iopr_pkg::STATUS_OVERLAP;
                     state_in      = ST_FIN;
                  end else if (ent_first < nfirst_ff) begin
                     pos_in = pos_ff + 1'b1;
                  end
               end
            end else if (scan_ff >= count_ff) begin
               if (!op_add_ff) begin
                  res_status_in = iopr_pkg::STATUS_MISS;
                  state_in      = ST_FIN;
               end else if (count_ff >= CNT_W'(MAX_RANGES)) begin
                  res_status_in = iopr_pkg::STATUS_FULL;
                  state_in      = ST_FIN;
               end else begin
                  scan_in  = count_ff;
                  pend_in  = 1'b0;
                  state_in = ST_SHIFT;
               end
            end
         end

         ST_SHIFT: begin
            // read entry j, write it back at j + 1 in the next cycle
            mem_rd_addr = scan_m1[IDX_W-1:0];
            if (scan_ff > pos_ff) begin
               mem_rd_en   = 1'b1;
               scan_in     = scan_m1;
               pend_in     = 1'b1;
               pend_idx_in = scan_m1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               mem_wr_en = 1'b1;
            end else if (scan_ff <= pos_ff) begin
               mem_wr_en     = 1'b1;
               mem_wr_addr   = pos_ff[IDX_W-1:0];
               mem_wr_data   = {nfirst_ff, nlast_ff, nhand_ff, nkind_ff};
               count_in      = count_ff + 1'b1;
               res_status_in = iopr_pkg::STATUS_ADDED;
               res_index_in  = pos_ff;
               state_in      = ST_FIN;
            end
         end

         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = res_status_ff;
               rsp_handler_in = res_handler_ff;
               rsp_kind_in    = res_kind_ff;
               rsp_index_in   = 4'(res_index_ff[IDX_W-1:0]);
               if (res_status_ff == iopr_pkg::STATUS_HIT ||
                   res_status_ff == iopr_pkg::STATUS_MISS) begin
                  rsp_port_in  = port_ff;
                  rsp_rd_in    = rd_ff;
                  rsp_bytes_in = bytes_ff;
               end else begin
                  rsp_port_in  = '0;
                  rsp_rd_in    = 1'b0;
                  rsp_bytes_in = '0;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_add_ff      <= op_add_in;
      scan_ff        <= scan_in;
      pend_idx_ff    <= pend_idx_in;
      pos_ff         <= pos_in;
      port_ff        <= port_in;
      rd_ff          <= rd_in;
      bytes_ff       <= bytes_in;
      nfirst_ff      <= nfirst_in;
      nlast_ff       <= nlast_in;
      nhand_ff       <= nhand_in;
      nkind_ff       <= nkind_in;
      res_status_ff  <= res_status_in;
      res_handler_ff <= res_handler_in;
      res_kind_ff    <= res_kind_in;
      res_index_ff   <= res_index_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_handler_ff <= rsp_handler_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_port_ff    <= rsp_port_in;
      rsp_rd_ff      <= rsp_rd_in;
      rsp_bytes_ff   <= rsp_bytes_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hit_handler = rsp_handler_ff;
   assign rsp_hit_kind    = rsp_kind_ff;
   assign rsp_hit_index   = rsp_index_ff;
   assign rsp_fwd_port    = rsp_port_ff;
   assign rsp_fwd_is_read = rsp_rd_ff;
   assign rsp_fwd_bytes   = rsp_bytes_ff;

endmodule

// ===== sv/iopr_checker.sv =====
// ----------------------------------------------------------------------------
// iopr_checker
// port level checks of the i/o port range table
// ----------------------------------------------------------------------------
module iopr_checker #(
   parameter int PORT_BITS    = 16,
   parameter int HANDLER_BITS = 8
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic [1:0]              req_type,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [2:0]              rsp_status,
   input logic [HANDLER_BITS-1:0] rsp_hit_handler,
   input logic                    rsp_hit_kind,
   input logic [3:0]              rsp_hit_index,
   input logic [PORT_BITS-1:0]    rsp_fwd_port,
   input logic                    rsp_fwd_is_read,
   input logic [2:0]              rsp_fwd_bytes
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_hit_handler) && $stable(rsp_hit_index))
      else $error("stalled response word changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_type == iopr_pkg::REQ_LOOKUP ||
         req_type == iopr_pkg::REQ_ADD || req_type == iopr_pkg::REQ_CLEAR)
         |=> req_stall)
      else $error("request taken while another is in progress");

   a_hit_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != iopr_pkg::STATUS_HIT
         |-> rsp_hit_handler == '0 && !rsp_hit_kind)
      else $error("handler or kind set without a hit");

   a_fwd_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != iopr_pkg::STATUS_HIT &&
         rsp_status != iopr_pkg::STATUS_MISS
         |-> rsp_fwd_port == '0 && !rsp_fwd_is_read && rsp_fwd_bytes == '0)
      else $error("dispatch fields set on a table update");

endmodule

bind io_port_range_table_unit iopr_checker #(
   .PORT_BITS    (PORT_BITS),
   .HANDLER_BITS (HANDLER_BITS)
) u_iopr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_type        (req_type),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_hit_handler (rsp_hit_handler),
   .rsp_hit_kind    (rsp_hit_kind),
   .rsp_hit_index   (rsp_hit_index),
   .rsp_fwd_port    (rsp_fwd_port),
   .rsp_fwd_is_read (rsp_fwd_is_read),
   .rsp_fwd_bytes   (rsp_fwd_bytes)
);

// ===== dv/tb_io_port_range_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_io_port_range_table_unit
// self-checking bench for the sorted i/o port range table
//
// Sends lookup, add, clear and unused request words through the valid/stall
// handshake. A model of the sorted table in the bench predicts each response
// word at the moment the request is accepted, and a checker compares every
// response field by field. The stimulus has a directed part for edge ports,
// inclusive-end overlaps, inverted ranges and odd access sizes. The random
// part fills and probes the table in rounds opened by a clear, runs a stretch
// with no idling, and ends with unstructured noise. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_io_port_range_table_unit;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int                     TABLE_DEPTH  = 16;
   localparam int                     STALL_LIMIT  = 5000;
   localparam int                     DRAIN_CYCLES = 64;
   localparam iopr_pkg::req_code_type REQ_UNUSED   = 2'd3;

   typedef struct packed {
      iopr_pkg::status_type status;
      logic [7:0]           handler;
      logic                 kind;
      logic [3:0]           index;
      logic [15:0]          port;
      logic                 rd;
      logic [2:0]           bytes;
   } range_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = iopr_pkg::REQ_LOOKUP;
   logic [15:0] req_port_number = '0;
   logic        req_is_read = 1'b0;
   logic [2:0]  req_access_bytes = 3'd1;
   logic [15:0] req_new_start = '0;
   logic [15:0] req_new_end = '0;
   logic [7:0]  req_new_handler = '0;
   logic        req_new_kind = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_hit_handler;
   logic        rsp_hit_kind;
   logic [3:0]  rsp_hit_index;
   logic [15:0] rsp_fwd_port;
   logic        rsp_fwd_is_read;
   logic [2:0]  rsp_fwd_bytes;

   // bench copy of the table
   logic [15:0] tbl_first [TABLE_DEPTH];
   logic [15:0] tbl_last [TABLE_DEPTH];
   logic [7:0]  tbl_handler [TABLE_DEPTH];
   logic        tbl_kind [TABLE_DEPTH];
   int          tbl_count = 0;

   range_result_type pending_words [$];
   int               mismatch_count = 0;
   int               answered_items = 0;
   int               status_tally [6];
   bit               no_idle = 1'b0;

   io_port_range_table_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_port_number  (req_port_number),
      .req_is_read      (req_is_read),
      .req_access_bytes (req_access_bytes),
      .req_new_start    (req_new_start),
      .req_new_end      (req_new_end),
      .req_new_handler  (req_new_handler),
      .req_new_kind     (req_new_kind),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_hit_handler  (rsp_hit_handler),
      .rsp_hit_kind     (rsp_hit_kind),
      .rsp_hit_index    (rsp_hit_index),
      .rsp_fwd_port     (rsp_fwd_port),
      .rsp_fwd_is_read  (rsp_fwd_is_read),
      .rsp_fwd_bytes    (rsp_fwd_bytes)
   );

   always #5 clock = ~clock;

   function automatic bit predict_range_table(input iopr_pkg::req_code_type rt,
                                              input logic [15:0] port,
                                              input logic rd, input logic [2:0] bytes,
                                              input logic [15:0] first_p,
                                              input logic [15:0] last_p,
                                              input logic [7:0] hnd, input logic knd,
                                              output range_result_type res);
      int i;
      int pos;
      bit rejected;
      res = '0;
      pos = 0;
      rejected = 1'b0;
      case (rt)
         iopr_pkg::REQ_LOOKUP: begin
            res.status = iopr_pkg::STATUS_MISS;
            res.port = port;
            res.rd = rd;
            res.bytes = bytes;
            for (i = 0; i < tbl_count; i++) begin
               if (res.status == iopr_pkg::STATUS_MISS && tbl_first[i] <= port &&
                   port <= tbl_last[i]) begin
                  res.status = iopr_pkg::STATUS_HIT;
                  res.handler = tbl_handler[i];
                  res.kind = tbl_kind[i];
                  res.index = i[3:0];
               end
            end
            return 1'b1;
         end
         iopr_pkg::REQ_ADD: begin
            if (first_p > last_p) begin
               res.status = iopr_pkg::STATUS_OVERLAP;
               return 1'b1;
            end
            for (i = 0; i < tbl_count; i++) begin
               if (tbl_last[i] >= first_p && tbl_first[i] <= last_p) rejected = 1'b1;
               if (tbl_first[i] < first_p) pos++;
            end
            if (rejected) begin
               res.status = iopr_pkg::STATUS_OVERLAP;
            end else if (tbl_count >= TABLE_DEPTH) begin
               res.status = iopr_pkg::STATUS_FULL;
            end else begin
               for (i = tbl_count; i > pos; i--) begin
                  tbl_first[i] = tbl_first[i-1];
                  tbl_last[i] = tbl_last[i-1];
                  tbl_handler[i] = tbl_handler[i-1];
                  tbl_kind[i] = tbl_kind[i-1];
               end
               tbl_first[pos] = first_p;
               tbl_last[pos] = last_p;
               tbl_handler[pos] = hnd;
               tbl_kind[pos] = knd;
               tbl_count++;
               res.status = iopr_pkg::STATUS_ADDED;
               res.index = pos[3:0];
            end
            return 1'b1;
         end
         iopr_pkg::REQ_CLEAR: begin
            tbl_count = 0;
            res.status = iopr_pkg::STATUS_CLEARED;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic drive_request(input iopr_pkg::req_code_type rt, input logic [15:0] port,
                                input logic rd, input logic [2:0] bytes,
                                input logic [15:0] first_p, input logic [15:0] last_p,
                                input logic [7:0] hnd, input logic knd);
      range_result_type res;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= rt;
      req_port_number <= port;
      req_is_read <= rd;
      req_access_bytes <= bytes;
      req_new_start <= first_p;
      req_new_end <= last_p;
      req_new_handler <= hnd;
      req_new_kind <= knd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_range_table(rt, port, rd, bytes, first_p, last_p, hnd, knd, res)) begin
         pending_words.push_back(res);
         answered_items++;
         status_tally[res.status]++;
      end
   endtask

   task automatic do_lookup(input logic [15:0] port, input logic rd, input logic [2:0] bytes);
      drive_request(iopr_pkg::REQ_LOOKUP, port, rd, bytes, 16'($urandom), 16'($urandom),
                    8'($urandom), 1'($urandom));
   endtask

   task automatic do_add(input logic [15:0] first_p, input logic [15:0] last_p,
                         input logic [7:0] hnd, input logic knd);
      drive_request(iopr_pkg::REQ_ADD, 16'($urandom), 1'($urandom), 3'($urandom),
                    first_p, last_p, hnd, knd);
   endtask

   task automatic do_clear();
      drive_request(iopr_pkg::REQ_CLEAR, 16'($urandom), 1'($urandom), 3'($urandom),
                    16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
   endtask

   // one clear followed by a mix of adds and lookups aimed at stored ranges
   task automatic fill_round(input int steps);
      int          n;
      int          j;
      logic [15:0] first_p;
      logic [15:0] last_p;
      logic [15:0] port;
      do_clear();
      for (n = 0; n < steps; n++) begin
         if ($urandom_range(99) < 45) begin
            if (tbl_count > 0 && $urandom_range(9) == 0) begin
               j = $urandom_range(tbl_count - 1);
               first_p = tbl_last[j] + 16'd1;
            end else begin
               first_p = 16'($urandom_range(31) * 2048 + $urandom_range(1500));
            end
            if ($urandom_range(19) == 0) last_p = first_p;
            else if ($urandom_range(29) == 0) last_p = first_p - 16'd1;
            else last_p = (int'(first_p) + $urandom_range(600) > 65535) ? 16'hFFFF
                                 : 16'(int'(first_p) + $urandom_range(600));
            do_add(first_p, last_p, 8'($urandom), 1'($urandom));
         end else begin
            port = 16'($urandom);
            if (tbl_count > 0 && $urandom_range(9) < 7) begin
               j = $urandom_range(tbl_count - 1);
               case ($urandom_range(4))
                  0: port = tbl_first[j];
                  1: port = tbl_last[j];
                  2: port = 16'((int'(tbl_first[j]) + int'(tbl_last[j])) / 2);
                  3: port = tbl_first[j] - 16'd1;
                  default: port = tbl_last[j] + 16'd1;
               endcase
            end
            do_lookup(port, 1'($urandom), ($urandom_range(9) == 0) ? 3'($urandom)
                                                                     : 3'($urandom_range(1, 4)));
         end
      end
   endtask

   task automatic test_directed();
      do_lookup(16'h0000, 1'b0, 3'd1);
      do_lookup(16'hFFFF, 1'b1, 3'd4);
      do_add(16'h0000, 16'h0000, 8'hFF, 1'b1);
      do_add(16'hFFFF, 16'hFFFF, 8'h00, 1'b0);
      do_add(16'h0010, 16'h0020, 8'h5A, 1'b1);
      do_lookup(16'h0000, 1'b1, 3'd0);
      do_lookup(16'hFFFF, 1'b0, 3'd7);
      do_lookup(16'h0010, 1'b1, 3'd2);
      do_lookup(16'h0020, 1'b0, 3'd3);
      do_lookup(16'h0021, 1'b1, 3'd5);
      do_lookup(16'h000F, 1'b0, 3'd6);
      do_add(16'h0020, 16'h0030, 8'hA5, 1'b0);
      do_add(16'h0005, 16'h0010, 8'h11, 1'b1);
      do_add(16'h0021, 16'h0030, 8'hC3, 1'b0);
      do_add(16'h0100, 16'h0050, 8'h22, 1'b1);
      do_add(16'h0001, 16'hFFFE, 8'h33, 1'b0);
      drive_request(REQ_UNUSED, 16'h1234, 1'b1, 3'd2, 16'h0200, 16'h0300, 8'h44, 1'b1);
      do_lookup(16'h0030, 1'b1, 3'd2);
      do_clear();
      do_lookup(16'h0010, 1'b1, 3'd3);
      do_clear();
   endtask

   task automatic test_fill_rounds(input int target);
      while (answered_items < target) fill_round($urandom_range(8, 40));
   endtask

   task automatic test_back_to_back(input int target);
      no_idle = 1'b1;
      test_fill_rounds(target);
      no_idle = 1'b0;
   endtask

   task automatic test_noise(input int target);
      while (answered_items < target)
         drive_request(iopr_pkg::req_code_type'($urandom_range(3)), 16'($urandom),
                       1'($urandom), 3'($urandom), 16'($urandom), 16'($urandom),
                       8'($urandom), 1'($urandom));
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      range_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response word, expected none, actual status %0h",
                     $time, rsp_status);
         end else begin
            want = pending_words.pop_front();
            compare_field("status", 16'(want.status), 16'(rsp_status));
            compare_field("hit_handler", 16'(want.handler), 16'(rsp_hit_handler));
            compare_field("hit_kind", 16'(want.kind), 16'(rsp_hit_kind));
            compare_field("hit_index", 16'(want.index), 16'(rsp_hit_index));
            compare_field("fwd_port", want.port, rsp_fwd_port);
            compare_field("fwd_is_read", 16'(want.rd), 16'(rsp_fwd_is_read));
            compare_field("fwd_bytes", 16'(want.bytes), 16'(rsp_fwd_bytes));
         end
      end
   end

   always @(negedge clock) rsp_stall <= !no_idle && ($urandom_range(99) < 13);

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_rounds(570);
      test_back_to_back(690);
      test_noise(850);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_words.size() != 0) mismatch_count++;
      $display("covered %0d answered requests: %0d hits, %0d misses, %0d adds",
               answered_items, status_tally[iopr_pkg::STATUS_HIT],
               status_tally[iopr_pkg::STATUS_MISS], status_tally[iopr_pkg::STATUS_ADDED]);
      $display("rejected %0d overlapping or inverted, %0d into a full table, %0d clears",
               status_tally[iopr_pkg::STATUS_OVERLAP], status_tally[iopr_pkg::STATUS_FULL],
               status_tally[iopr_pkg::STATUS_CLEARED]);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
